// ===== rtl/core/lzss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_pkg: shared types and constants of the LZSS stream decompressor
// Ring geometry, match limits, sequencer states and the ring request bundle.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // History ring geometry
  localparam int unsigned RingSize = 4096;
  localparam int unsigned RingAw   = $clog2(RingSize);
  localparam int unsigned MaxMatch = 18;
  localparam int unsigned MinMatch = 3;
  localparam int unsigned LenW     = $clog2(MaxMatch + 1);
  localparam int unsigned FillW    = RingAw + 1;

  // Start of a stream: write position and initial ring contents
  localparam logic [RingAw-1:0] FillStart = RingAw'(RingSize - MaxMatch);
  localparam logic [7:0]        SpaceByte = 8'h20;
  localparam logic [7:0]        ZeroByte  = 8'h00;
  localparam logic [3:0]        FlagCount = 4'd8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LIT,
    ST_COPY
  } ctrl_state_e;

  // One cycle of ring traffic from the sequencer
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [RingAw-1:0] rd_addr;
    logic              wr_en;
    logic [RingAw-1:0] wr_addr;
    logic [7:0]        wr_data;
  } ring_req_t;

endpackage

// ===== rtl/core/lzss_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_if: request channels of the LZSS stream decompressor
// Compressed input channel and decompressed output channel, valid/ready.
// ----------------------------------------------------------------------------
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input stream_done, output ready);
endinterface

// ===== rtl/core/lzss_stream_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor: LZSS decoder, 4096-byte window, matches 3 to 18
// Top level: output length register, parser/copy sequencer and history ring.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        in_byte[7:0], new_stream
//  out_o    out  valid/ready        out_byte[7:0], last_of_run, stream_done
//  cfg      in   cfg_we_i (no ack)  cfg_wdata_i[31:0] = output_length
//
//  Flag and first reference bytes pass the decode state, a literal then the
//  literal state, a second reference byte a copy of L bytes (3..18): one ring
//  read and one write port, so a copy moves one byte a cycle unless stalled.
//  in_i.ready is high only while the sequencer is idle.
//  Reset clears control state; the ring needs no clearing pass, a fill count
//  supplies the start image, so the block is ready right after reset.
//  A stalled out_o holds the copy in place without losing bytes.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzss_in_if.sink     in_i,
  lzss_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]         output_length_q;
  lzss_pkg::ring_req_t ring_req;
  logic [7:0]          ring_byte;

  // Output length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_length_q <= '0;
    end else if (cfg_we_i) begin
      output_length_q <= cfg_wdata_i;
    end
  end

  lzss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .out_o           (out_o),
    .output_length_i (output_length_q),
    .ring_req_o      (ring_req),
    .ring_byte_i     (ring_byte)
  );

  lzss_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_byte_o (ring_byte)
  );

`ifndef SYNTHESIS
  // Every ring write is a byte presented on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.wr_en |=> out_o.valid)
    else $error("ring write without output byte");

  // The end of a stream always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stream_done) |-> out_o.last_of_run)
    else $error("stream_done without last_of_run");

  // One request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second request taken while busy");

  // Ring reads happen only during a copy, never while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.rd_en |-> (!in_i.ready && !ring_req.clear))
    else $error("ring read outside a copy");
`endif

endmodule

// ===== rtl/core/lzss_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ring: 4096-byte history ring
// Single-port-write memory with registered read, a fill count standing in
// for the space/zero start image, and a bypass for a same-cycle write.
// ----------------------------------------------------------------------------
module lzss_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzss_pkg::ring_req_t req_i,
  output logic [7:0]          rd_byte_o
);

  logic [7:0]                     ring_mem_q [lzss_pkg::RingSize];
  logic [7:0]                     rd_data_q;
  logic [lzss_pkg::FillW-1:0]     fill_q, fill_d;
  logic                           hit_q;
  logic                           fwd_q;
  logic [7:0]                     fwd_byte_q;
  logic [7:0]                     start_byte_q;
  logic [lzss_pkg::RingAw-1:0]    rd_ofs;
  logic                           rd_hit;

  // Entries are written in order from the stream start, so an entry is
  // live when its distance from the start is below the fill count
  assign rd_ofs = req_i.rd_addr - lzss_pkg::FillStart;
  assign rd_hit = {1'b0, rd_ofs} < fill_q;

  // Count written entries, saturate at a full ring
  always_comb begin
    fill_d = fill_q;
    if (req_i.clear) begin
      fill_d = '0;
    end else if (req_i.wr_en && fill_q != lzss_pkg::FillW'(lzss_pkg::RingSize)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Memory array: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      ring_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= ring_mem_q[req_i.rd_addr];
    end
  end

  // Capture read qualifiers and the bypass byte alongside the read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      hit_q        <= rd_hit;
      fwd_q        <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);
      fwd_byte_q   <= req_i.wr_data;
      start_byte_q <= (req_i.rd_addr < lzss_pkg::FillStart) ? lzss_pkg::SpaceByte
                                                            : lzss_pkg::ZeroByte;
    end
  end

  // Pick bypass, stored byte or start image
  assign rd_byte_o = fwd_q ? fwd_byte_q : (hit_q ? rd_data_q : start_byte_q);

endmodule

// ===== rtl/core/lzss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ctrl: parser and copy sequencer
// Decodes flag, literal and reference bytes, steps the ring address unit
// through a match one byte per cycle unless out_o stalls, and holds the output register.
// ----------------------------------------------------------------------------
module lzss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  lzss_in_if.sink             in_i,
  lzss_out_if.source          out_o,
  input  logic [31:0]         output_length_i,
  output lzss_pkg::ring_req_t ring_req_o,
  input  logic [7:0]          ring_byte_i
);

  localparam int unsigned Aw = lzss_pkg::RingAw;
  localparam int unsigned Lw = lzss_pkg::LenW;

  lzss_pkg::ctrl_state_e state_q, state_d;

  logic [7:0]    byte_q, byte_d;
  logic [Aw-1:0] wr_pos_q, wr_pos_d;
  logic [7:0]    flag_bits_q, flag_bits_d;
  logic [3:0]    flags_left_q, flags_left_d;
  logic          ref_phase_q, ref_phase_d;
  logic [7:0]    pos_low_q, pos_low_d;
  logic [31:0]   bytes_left_q, bytes_left_d;
  logic          finished_q, finished_d;
  logic [Aw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Lw-1:0] rd_left_q, rd_left_d;
  logic [Lw-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_done_q, out_done_d;

  logic          accept;
  logic          slot_free;
  logic          halted;
  logic          copy_emit;
  logic          copy_stop;
  logic          emit_en;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic [Lw-1:0] ref_len;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == lzss_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || out_o.ready;
  assign halted    = finished_q || (bytes_left_q == 32'd0);
  assign copy_emit = pend_q && slot_free;
  assign copy_stop = (cnt_q == Lw'(1)) || (bytes_left_q == 32'd1);
  assign ref_len   = Lw'(byte_q[3:0]) + Lw'(lzss_pkg::MinMatch);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzss_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lzss_pkg::ST_DECODE;
        end
      end
      lzss_pkg::ST_DECODE: begin
        if (halted) begin
          state_d = lzss_pkg::ST_IDLE;
        end else if (ref_phase_q) begin
          state_d = lzss_pkg::ST_COPY;
        end else if (flags_left_q != 4'd0 && flag_bits_q[0]) begin
          state_d = lzss_pkg::ST_LIT;
        end else begin
          state_d = lzss_pkg::ST_IDLE;
        end
      end
      lzss_pkg::ST_LIT: begin
        if (slot_free) begin
          state_d = lzss_pkg::ST_IDLE;
        end
      end
      lzss_pkg::ST_COPY: begin
        if (copy_emit && copy_stop) begin
          state_d = lzss_pkg::ST_IDLE;
        end
      end
      default: state_d = lzss_pkg::ST_IDLE;
    endcase
  end

  // Datapath and ring traffic
  always_comb begin
    byte_d       = byte_q;
    wr_pos_d     = wr_pos_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    ref_phase_d  = ref_phase_q;
    pos_low_d    = pos_low_q;
    bytes_left_d = bytes_left_q;
    finished_d   = finished_q;
    rd_ptr_d     = rd_ptr_q;
    rd_left_d    = rd_left_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    emit_en      = 1'b0;
    emit_byte    = byte_q;
    emit_last    = 1'b0;
    ring_req_o   = '0;

    unique case (state_q)
      lzss_pkg::ST_IDLE: begin
        // Take the request, restart the stream when asked
        if (accept) begin
          byte_d = in_i.in_byte;
          if (in_i.new_stream) begin
            wr_pos_d         = lzss_pkg::FillStart;
            flag_bits_d      = '0;
            flags_left_d     = '0;
            ref_phase_d      = 1'b0;
            pos_low_d        = '0;
            bytes_left_d     = output_length_i;
            finished_d       = 1'b0;
            ring_req_o.clear = 1'b1;
          end
        end
      end
      lzss_pkg::ST_DECODE: begin
        if (!halted) begin
          if (ref_phase_q) begin
            // Second reference byte: load the copy
            ref_phase_d  = 1'b0;
            flag_bits_d  = {1'b0, flag_bits_q[7:1]};
            flags_left_d = flags_left_q - 4'd1;
            rd_ptr_d     = {byte_q[7:4], pos_low_q};
            rd_left_d    = ref_len;
            cnt_d        = ref_len;
            pend_d       = 1'b0;
          end else if (flags_left_q == 4'd0) begin
            flag_bits_d  = byte_q;
            flags_left_d = lzss_pkg::FlagCount;
          end else if (flag_bits_q[0]) begin
            flag_bits_d  = {1'b0, flag_bits_q[7:1]};
            flags_left_d = flags_left_q - 4'd1;
          end else begin
            pos_low_d   = byte_q;
            ref_phase_d = 1'b1;
          end
        end
      end
      lzss_pkg::ST_LIT: begin
        emit_en   = slot_free;
        emit_byte = byte_q;
        emit_last = 1'b1;
      end
      lzss_pkg::ST_COPY: begin
        emit_en   = copy_emit;
        emit_byte = ring_byte_i;
        emit_last = copy_stop;
        if (copy_emit) begin
          cnt_d  = cnt_q - Lw'(1);
          pend_d = 1'b0;
        end
        // Issue the next ring read once the held byte is gone
        if (rd_left_q != '0 && (!pend_q || copy_emit) && !(copy_emit && copy_stop)) begin
          ring_req_o.rd_en   = 1'b1;
          ring_req_o.rd_addr = rd_ptr_q;
          rd_ptr_d           = rd_ptr_q + 1'b1;
          rd_left_d          = rd_left_q - Lw'(1);
          pend_d             = 1'b1;
        end
      end
      default: ;
    endcase

    // Write the emitted byte back to the ring and count it
    if (emit_en) begin
      ring_req_o.wr_en   = 1'b1;
      ring_req_o.wr_addr = wr_pos_q;
      ring_req_o.wr_data = emit_byte;
      wr_pos_d           = wr_pos_q + 1'b1;
      bytes_left_d       = bytes_left_q - 32'd1;
      if (bytes_left_q == 32'd1) begin
        finished_d = 1'b1;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (emit_en) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
      out_done_d  = (bytes_left_q == 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzss_pkg::ST_IDLE;
      wr_pos_q     <= lzss_pkg::FillStart;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      ref_phase_q  <= 1'b0;
      pos_low_q    <= '0;
      bytes_left_q <= '0;
      finished_q   <= 1'b0;
      rd_left_q    <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_pos_q     <= wr_pos_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      ref_phase_q  <= ref_phase_d;
      pos_low_q    <= pos_low_d;
      bytes_left_q <= bytes_left_d;
      finished_q   <= finished_d;
      rd_left_q    <= rd_left_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    rd_ptr_q   <= rd_ptr_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.stream_done = out_done_q;

endmodule
